// ===== src/qau_pkg.sv =====
`default_nettype none

package qau_pkg;

  localparam int unsigned CW    = 32;
  localparam int unsigned FB    = 16;
  localparam int unsigned PW    = 2 * CW;
  localparam int unsigned AW    = 2 * CW + 3;
  localparam int unsigned DW    = (CW + 2 * FB > 2 * CW + 1) ? CW + 2 * FB : 2 * CW + 1;
  localparam int unsigned NW    = DW + 1;
  localparam int unsigned SW    = 2 * CW + 2;
  localparam int unsigned RW    = CW + 4;
  localparam int unsigned NPROD = 16;
  localparam int unsigned NSQ   = 4;
  localparam int unsigned MCW   = $clog2(NPROD + 1);
  localparam int unsigned DCW   = $clog2(DW + 1);
  localparam int unsigned SCW   = $clog2(SW / 2 + 1);
  localparam int unsigned QD    = 2;
  localparam int unsigned QAW   = $clog2(QD);

  localparam logic [2:0] OP_MUL  = 3'd0;
  localparam logic [2:0] OP_CONJ = 3'd1;
  localparam logic [2:0] OP_DIV  = 3'd2;
  localparam logic [2:0] OP_NORM = 3'd3;
  localparam logic [2:0] OP_INV  = 3'd4;

  localparam logic [1:0] STAT_OK  = 2'd0;
  localparam logic [1:0] STAT_DZ  = 2'd1;
  localparam logic [1:0] STAT_SAT = 2'd2;

  localparam logic signed [CW-1:0] SMAX = {1'b0, {(CW - 1){1'b1}}};
  localparam logic signed [CW-1:0] SMIN = {1'b1, {(CW - 1){1'b0}}};

  typedef enum logic [2:0] {
    CLS_MUL, CLS_CONJ, CLS_DIV, CLS_NORM, CLS_INV, CLS_NONE
  } cls_e;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_DLOAD, S_DIV, S_SQRT, S_WRAP
  } state_e;

  typedef struct packed {
    logic [2:0]           op;
    logic signed [CW-1:0] a_w, a_x, a_y, a_z;
    logic signed [CW-1:0] b_w, b_x, b_y, b_z;
    logic signed [CW-1:0] divisor;
  } in_item_t;

  typedef struct packed {
    logic signed [CW-1:0] r_w, r_x, r_y, r_z;
    logic [CW-2:0]        norm_value;
    logic                 a_is_zero;
    logic [1:0]           status;
  } out_item_t;

  typedef struct packed {
    cls_e                cls;
    logic                a_is_zero;
    logic [3:0][CW-1:0]  a;
    logic [3:0][CW-1:0]  b;
    logic [CW-1:0]       divisor;
  } task_t;

  typedef struct packed {
    logic [1:0] ai;
    logic [1:0] bi;
    logic [1:0] tgt;
    logic       neg;
  } msel_t;

  typedef struct packed {
    logic signed [CW-1:0] v;
    logic                 s;
  } satr_t;

  typedef struct packed {
    logic          start;
    logic [DW-1:0] n;
    logic [DW-1:0] d;
  } div_req_t;

  typedef struct packed {
    logic          done;
    logic [DW-1:0] q;
  } div_rsp_t;

  // Hamilton product schedule: four terms per component
  function automatic msel_t mul_sel(input logic [3:0] k);
    msel_t s;
    unique case (k)
      4'd0:  s = '{2'd0, 2'd0, 2'd0, 1'b0};
      4'd1:  s = '{2'd1, 2'd1, 2'd0, 1'b1};
      4'd2:  s = '{2'd2, 2'd2, 2'd0, 1'b1};
      4'd3:  s = '{2'd3, 2'd3, 2'd0, 1'b1};
      4'd4:  s = '{2'd0, 2'd1, 2'd1, 1'b0};
      4'd5:  s = '{2'd1, 2'd0, 2'd1, 1'b0};
      4'd6:  s = '{2'd2, 2'd3, 2'd1, 1'b0};
      4'd7:  s = '{2'd3, 2'd2, 2'd1, 1'b1};
      4'd8:  s = '{2'd0, 2'd2, 2'd2, 1'b0};
      4'd9:  s = '{2'd2, 2'd0, 2'd2, 1'b0};
      4'd10: s = '{2'd3, 2'd1, 2'd2, 1'b0};
      4'd11: s = '{2'd1, 2'd3, 2'd2, 1'b1};
      4'd12: s = '{2'd0, 2'd3, 2'd3, 1'b0};
      4'd13: s = '{2'd3, 2'd0, 2'd3, 1'b0};
      4'd14: s = '{2'd1, 2'd2, 2'd3, 1'b0};
      4'd15: s = '{2'd2, 2'd1, 2'd3, 1'b1};
      default: s = '0;
    endcase
    return s;
  endfunction

  function automatic satr_t sat_acc(input logic signed [AW-1:0] x);
    satr_t r;
    logic signed [AW-1:0] maxv;
    logic signed [AW-1:0] minv;
    maxv = {{(AW - CW + 1){1'b0}}, {(CW - 1){1'b1}}};
    minv = ~maxv;
    if (x > maxv) begin
      r.v = SMAX;
      r.s = 1'b1;
    end else if (x < minv) begin
      r.v = SMIN;
      r.s = 1'b1;
    end else begin
      r.v = x[CW-1:0];
      r.s = 1'b0;
    end
    return r;
  endfunction

  function automatic satr_t sat_quot(input logic [DW-1:0] q, input logic neg);
    satr_t r;
    logic [DW-1:0] lim;
    lim = '0;
    lim[CW-1] = 1'b1;
    if (neg) begin
      if (q > lim) begin
        r.v = SMIN;
        r.s = 1'b1;
      end else begin
        r.v = -q[CW-1:0];
        r.s = 1'b0;
      end
    end else begin
      if (q >= lim) begin
        r.v = SMAX;
        r.s = 1'b1;
      end else begin
        r.v = q[CW-1:0];
        r.s = 1'b0;
      end
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/qau_front.sv =====
`default_nettype none

module qau_front (
  input  qau_pkg::in_item_t item_i,
  output qau_pkg::task_t    task_o
);
  import qau_pkg::*;

  always_comb begin
    task_o.a         = {item_i.a_z, item_i.a_y, item_i.a_x, item_i.a_w};
    task_o.b         = {item_i.b_z, item_i.b_y, item_i.b_x, item_i.b_w};
    task_o.divisor   = item_i.divisor;
    task_o.a_is_zero = (task_o.a == '0);
    unique case (item_i.op)
      OP_MUL:  task_o.cls = CLS_MUL;
      OP_CONJ: task_o.cls = CLS_CONJ;
      OP_DIV:  task_o.cls = CLS_DIV;
      OP_NORM: task_o.cls = CLS_NORM;
      OP_INV:  task_o.cls = CLS_INV;
      default: task_o.cls = CLS_NONE;
    endcase
  end

endmodule

`default_nettype wire

// ===== src/qau_fifo.sv =====
`default_nettype none

module qau_fifo (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  output logic           full_o,
  input  qau_pkg::task_t wdata_i,
  input  logic           pop_i,
  output logic           empty_o,
  output qau_pkg::task_t rdata_o
);
  import qau_pkg::*;

  task_t          mem_q [QD];
  logic [QAW-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QAW:0]   cnt_q, cnt_d;
  logic           wr_en, rd_en;

  assign full_o  = (cnt_q == (QAW + 1)'(QD));
  assign empty_o = (cnt_q == '0);
  assign wr_en   = push_i && !full_o;
  assign rd_en   = pop_i && !empty_o;
  assign rdata_o = mem_q[rd_q];

  always_comb begin
    wr_d  = wr_en ? wr_q + 1'b1 : wr_q;
    rd_d  = rd_en ? rd_q + 1'b1 : rd_q;
    cnt_d = cnt_q + (QAW + 1)'(wr_en) - (QAW + 1)'(rd_en);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_q] <= wdata_i;
    end
  end

endmodule

`default_nettype wire

// ===== src/qau_div.sv =====
`default_nettype none

module qau_div (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  qau_pkg::div_req_t req_i,
  output qau_pkg::div_rsp_t rsp_o
);
  import qau_pkg::*;

  logic [DW:0]    rem_q, rem_d, sh;
  logic [DW-1:0]  qn_q, qn_d, d_q;
  logic [DCW-1:0] cnt_q, cnt_d;
  logic           busy_q, busy_d, done_q, done_d;

  // restoring, one quotient bit a cycle
  always_comb begin
    rem_d  = rem_q;
    qn_d   = qn_q;
    cnt_d  = cnt_q;
    busy_d = busy_q;
    done_d = 1'b0;
    sh     = {rem_q[DW-1:0], qn_q[DW-1]};
    if (req_i.start) begin
      rem_d  = '0;
      qn_d   = req_i.n;
      cnt_d  = '0;
      busy_d = 1'b1;
    end else if (busy_q) begin
      if (sh >= {1'b0, d_q}) begin
        rem_d = sh - {1'b0, d_q};
        qn_d  = {qn_q[DW-2:0], 1'b1};
      end else begin
        rem_d = sh;
        qn_d  = {qn_q[DW-2:0], 1'b0};
      end
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == DCW'(DW - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q <= rem_d;
    qn_q  <= qn_d;
    if (req_i.start) begin
      d_q <= req_i.d;
    end
  end

  assign rsp_o.done = done_q;
  assign rsp_o.q    = qn_q;

endmodule

`default_nettype wire

// ===== src/qau_back.sv =====
`default_nettype none

module qau_back (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  qau_pkg::task_t     task_i,
  input  logic               task_empty_i,
  output logic               task_pop_o,
  output qau_pkg::out_item_t out_o,
  output logic               out_valid_o,
  input  logic               out_pop_i,
  output qau_pkg::div_req_t  div_req_o,
  input  qau_pkg::div_rsp_t  div_rsp_i
);
  import qau_pkg::*;

  state_e               state_q, state_d;
  cls_e                 cls_q;
  logic                 az_q;
  logic [3:0][CW-1:0]   a_q, b_q;
  logic [CW-1:0]        dv_q;
  logic signed [AW-1:0] acc_q [4];
  logic [MCW-1:0]       cnt_q;
  logic signed [PW-1:0] p_q;
  logic [1:0]           pt_q;
  logic                 pn_q, pv_q;
  logic [1:0]           comp_q;
  logic                 neg_q;
  logic signed [CW-1:0] r_q [4];
  logic [CW-2:0]        norm_q;
  logic                 dz_q, sat_q;
  logic [SW-1:0]        src_q;
  logic [RW-1:0]        srem_q;
  logic [CW:0]          root_q;
  logic [SCW-1:0]       scnt_q;
  out_item_t            out_q;
  logic                 ovld_q;

  logic [MCW-1:0]       np;
  logic                 last_mul, issue;
  msel_t                sel;
  logic [CW-1:0]        mop_a, mop_b;
  logic signed [AW-1:0] pe, addv, acc0_nx;
  logic signed [NW-1:0] num, den;
  logic                 den_zero;
  satr_t                qres;
  logic [RW-1:0]        sh, trial;
  logic                 ge, sq_last;
  logic [CW:0]          root_nx;
  logic                 space, wrap_go;
  out_item_t            fin;
  satr_t                fs [4];
  logic signed [CW-1:0] fr [4];
  logic                 fsat;

  // product issue
  always_comb begin
    np       = (cls_q == CLS_MUL) ? MCW'(NPROD) : MCW'(NSQ);
    last_mul = (cnt_q == np);
    issue    = (cnt_q < np);
    if (cls_q == CLS_MUL) begin
      sel = mul_sel(cnt_q[3:0]);
    end else begin
      sel = '{cnt_q[1:0], cnt_q[1:0], 2'd0, 1'b0};
    end
    mop_a   = a_q[sel.ai];
    mop_b   = (cls_q == CLS_MUL) ? b_q[sel.bi] : a_q[sel.ai];
    pe      = AW'(p_q);
    addv    = pn_q ? -pe : pe;
    acc0_nx = (pv_q && pt_q == 2'd0) ? acc_q[0] + addv : acc_q[0];
  end

  // division operands
  always_comb begin
    if (cls_q == CLS_DIV) begin
      num = NW'($signed(a_q[comp_q])) <<< FB;
      den = NW'($signed(dv_q));
    end else begin
      if (comp_q == 2'd0) begin
        num = NW'($signed(a_q[comp_q])) <<< (2 * FB);
      end else begin
        num = (-NW'($signed(a_q[comp_q]))) <<< (2 * FB);
      end
      den = NW'(acc_q[0]);
    end
    den_zero = (den == '0);
    qres     = sat_quot(div_rsp_i.q, neg_q);
  end

  // square root, one result bit a cycle
  always_comb begin
    sh      = {srem_q[RW-3:0], src_q[SW-1:SW-2]};
    trial   = {1'b0, root_q, 2'b01};
    ge      = (sh >= trial);
    root_nx = {root_q[CW-1:0], ge};
    sq_last = (scnt_q == SCW'(SW / 2 - 1));
  end

  // final result
  always_comb begin
    fsat = 1'b0;
    for (int i = 0; i < 4; i++) begin
      fs[i] = '0;
      fr[i] = r_q[i];
      if (cls_q == CLS_MUL) begin
        fs[i] = sat_acc(acc_q[i] >>> FB);
        fr[i] = fs[i].v;
      end else if (cls_q == CLS_CONJ) begin
        if (i == 0) begin
          fr[i] = a_q[0];
        end else begin
          fs[i] = sat_acc(-AW'($signed(a_q[i])));
          fr[i] = fs[i].v;
        end
      end
      fsat = fsat | fs[i].s;
    end
    fin.r_w        = fr[0];
    fin.r_x        = fr[1];
    fin.r_y        = fr[2];
    fin.r_z        = fr[3];
    fin.norm_value = norm_q;
    fin.a_is_zero  = az_q;
    if (dz_q) begin
      fin.status = STAT_DZ;
    end else if (sat_q || fsat) begin
      fin.status = STAT_SAT;
    end else begin
      fin.status = STAT_OK;
    end
  end

  assign space   = !ovld_q || out_pop_i;
  assign wrap_go = (state_q == S_WRAP) && space;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (!task_empty_i) begin
          unique case (task_i.cls)
            CLS_MUL, CLS_NORM, CLS_INV: state_d = S_MUL;
            CLS_DIV:                    state_d = S_DLOAD;
            default:                    state_d = S_WRAP;
          endcase
        end
      end
      S_MUL: begin
        if (last_mul) begin
          unique case (cls_q)
            CLS_NORM: state_d = S_SQRT;
            CLS_INV:  state_d = S_DLOAD;
            default:  state_d = S_WRAP;
          endcase
        end
      end
      S_DLOAD: begin
        if (!den_zero) begin
          state_d = S_DIV;
        end else if (comp_q == 2'd3) begin
          state_d = S_WRAP;
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          state_d = (comp_q == 2'd3) ? S_WRAP : S_DLOAD;
        end
      end
      S_SQRT: begin
        if (sq_last) begin
          state_d = S_WRAP;
        end
      end
      S_WRAP: begin
        if (space) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    task_pop_o      = (state_q == S_IDLE) && !task_empty_i;
    div_req_o.start = (state_q == S_DLOAD) && !den_zero;
    div_req_o.n     = num[NW-1] ? DW'(-num) : DW'(num);
    div_req_o.d     = den[NW-1] ? DW'(-den) : DW'(den);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovld_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      if (wrap_go) begin
        ovld_q <= 1'b1;
      end else if (out_pop_i) begin
        ovld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (wrap_go) begin
      out_q <= fin;
    end
    unique case (state_q)
      S_IDLE: begin
        if (!task_empty_i) begin
          cls_q  <= task_i.cls;
          az_q   <= task_i.a_is_zero;
          a_q    <= task_i.a;
          b_q    <= task_i.b;
          dv_q   <= task_i.divisor;
          cnt_q  <= '0;
          pv_q   <= 1'b0;
          comp_q <= 2'd0;
          dz_q   <= 1'b0;
          sat_q  <= 1'b0;
          norm_q <= '0;
          for (int i = 0; i < 4; i++) begin
            r_q[i]   <= '0;
            acc_q[i] <= '0;
          end
        end
      end
      S_MUL: begin
        if (issue) begin
          p_q  <= $signed(mop_a) * $signed(mop_b);
          pt_q <= sel.tgt;
          pn_q <= sel.neg;
        end
        pv_q  <= issue;
        cnt_q <= cnt_q + 1'b1;
        if (pv_q) begin
          acc_q[pt_q] <= acc_q[pt_q] + addv;
        end
        if (last_mul) begin
          src_q  <= acc0_nx[SW-1:0];
          srem_q <= '0;
          root_q <= '0;
          scnt_q <= '0;
        end
      end
      S_DLOAD: begin
        if (den_zero) begin
          dz_q <= 1'b1;
          if (num == '0) begin
            r_q[comp_q] <= '0;
          end else begin
            r_q[comp_q] <= num[NW-1] ? SMIN : SMAX;
          end
          comp_q <= comp_q + 1'b1;
        end else begin
          neg_q <= num[NW-1] ^ den[NW-1];
        end
      end
      S_DIV: begin
        if (div_rsp_i.done) begin
          r_q[comp_q] <= qres.v;
          sat_q       <= sat_q | qres.s;
          comp_q      <= comp_q + 1'b1;
        end
      end
      S_SQRT: begin
        src_q  <= {src_q[SW-3:0], 2'b00};
        srem_q <= ge ? sh - trial : sh;
        root_q <= root_nx;
        scnt_q <= scnt_q + 1'b1;
        if (sq_last) begin
          if (root_nx[CW:CW-1] != 2'b00) begin
            norm_q <= '1;
            sat_q  <= 1'b1;
          end else begin
            norm_q <= root_nx[CW-2:0];
          end
        end
      end
      default: begin
      end
    endcase
  end

  assign out_o       = out_q;
  assign out_valid_o = ovld_q;

endmodule

`default_nettype wire

// ===== src/quaternion_arithmetic_unit.sv =====
`default_nettype none

// channel   direction  handshake          payload
// input     in         push / full        in_item_i  (qau_pkg::in_item_t)
// result    out        pop / empty        out_item_o (qau_pkg::out_item_t)
//
// Two-entry queue parts the front from the execution unit; one result register.
// Conjugate and unknown op go straight to write-back; multiply runs 16 products on
// one 32x32 multiplier; norm runs 4 squares, then one root bit a cycle; inverse
// runs the 4 squares, then, like divide, the restoring divider one component at
// a time; a zero divisor skips the divider for that component.
// Asynchronous active-low reset empties the queue and the result register.
// A waiting result stalls the unit only at write-back; transfers continue in front.

module quaternion_arithmetic_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  qau_pkg::in_item_t  in_item_i,
  output logic               empty,
  input  logic               pop,
  output qau_pkg::out_item_t out_item_o
);
  import qau_pkg::*;

  task_t     task_w, task_r;
  logic      q_empty, q_pop, out_valid;
  div_req_t  div_req;
  div_rsp_t  div_rsp;

  qau_front u_front (
    .item_i (in_item_i),
    .task_o (task_w)
  );

  qau_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .full_o  (full),
    .wdata_i (task_w),
    .pop_i   (q_pop),
    .empty_o (q_empty),
    .rdata_o (task_r)
  );

  qau_div u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (div_req),
    .rsp_o  (div_rsp)
  );

  qau_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .task_i       (task_r),
    .task_empty_i (q_empty),
    .task_pop_o   (q_pop),
    .out_o        (out_item_o),
    .out_valid_o  (out_valid),
    .out_pop_i    (pop),
    .div_req_o    (div_req),
    .div_rsp_i    (div_rsp)
  );

  assign empty = !out_valid;

endmodule

`default_nettype wire

// ===== test/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import qau_pkg::*;

  localparam logic [2:0] OP_SPARE = 3'd5;
  localparam logic [2:0] OP_UNUSED = 3'd7;
  localparam int unsigned CYCLE_LIMIT = 2_000_000;
  localparam int unsigned N_RANDOM = 700;

  typedef logic signed [127:0] wide_t;

  class qau_scoreboard;
    out_item_t pending[$];
    int unsigned n_errors;
    int unsigned n_checked;
    int unsigned n_per_op[8];

    function logic [CW-1:0] clamp(input wide_t x, inout bit s);
      if (x > wide_t'(SMAX)) begin
        s = 1'b1;
        return SMAX;
      end
      if (x < wide_t'(SMIN)) begin
        s = 1'b1;
        return SMIN;
      end
      return x[CW-1:0];
    endfunction

    function logic [CW-1:0] quotient(input wide_t num, input wide_t den, inout bit dz,
                                     inout bit s);
      if (den == '0) begin
        dz = 1'b1;
        if (num == '0) return '0;
        return num[127] ? SMIN : SMAX;
      end
      return clamp(num / den, s);
    endfunction

    function out_item_t predict(input in_item_t it);
      out_item_t r;
      wide_t a[4];
      wide_t b[4];
      wide_t d;
      wide_t t[4];
      wide_t sq;
      logic [127:0] root;
      logic [127:0] trial;
      bit dz;
      bit s;
      a[0] = wide_t'(it.a_w); a[1] = wide_t'(it.a_x);
      a[2] = wide_t'(it.a_y); a[3] = wide_t'(it.a_z);
      b[0] = wide_t'(it.b_w); b[1] = wide_t'(it.b_x);
      b[2] = wide_t'(it.b_y); b[3] = wide_t'(it.b_z);
      d = wide_t'(it.divisor);
      dz = 1'b0;
      s = 1'b0;
      r = '0;
      sq = a[0] * a[0] + a[1] * a[1] + a[2] * a[2] + a[3] * a[3];
      case (it.op)
        OP_MUL: begin
          t[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
          t[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
          t[2] = a[0] * b[2] + a[2] * b[0] + a[3] * b[1] - a[1] * b[3];
          t[3] = a[0] * b[3] + a[3] * b[0] + a[1] * b[2] - a[2] * b[1];
          r.r_w = clamp(t[0] >>> FB, s);
          r.r_x = clamp(t[1] >>> FB, s);
          r.r_y = clamp(t[2] >>> FB, s);
          r.r_z = clamp(t[3] >>> FB, s);
        end
        OP_CONJ: begin
          r.r_w = clamp(a[0], s);
          r.r_x = clamp(-a[1], s);
          r.r_y = clamp(-a[2], s);
          r.r_z = clamp(-a[3], s);
        end
        OP_DIV: begin
          r.r_w = quotient(a[0] <<< FB, d, dz, s);
          r.r_x = quotient(a[1] <<< FB, d, dz, s);
          r.r_y = quotient(a[2] <<< FB, d, dz, s);
          r.r_z = quotient(a[3] <<< FB, d, dz, s);
        end
        OP_NORM: begin
          root = '0;
          for (int i = 63; i >= 0; i--) begin
            trial = root | (128'd1 << i);
            if (sq >= trial * trial) root = trial;
          end
          if (root > 128'({CW-1{1'b1}})) begin
            root = 128'({CW-1{1'b1}});
            s = 1'b1;
          end
          r.norm_value = root[CW-2:0];
        end
        OP_INV: begin
          r.r_w = quotient(a[0] <<< (2 * FB), sq, dz, s);
          r.r_x = quotient((-a[1]) <<< (2 * FB), sq, dz, s);
          r.r_y = quotient((-a[2]) <<< (2 * FB), sq, dz, s);
          r.r_z = quotient((-a[3]) <<< (2 * FB), sq, dz, s);
        end
        default: ;
      endcase
      r.a_is_zero = (it.a_w == '0 && it.a_x == '0 && it.a_y == '0 && it.a_z == '0);
      r.status = dz ? STAT_DZ : (s ? STAT_SAT : STAT_OK);
      return r;
    endfunction

    function void note_input(input in_item_t it);
      pending.push_back(predict(it));
      n_per_op[it.op]++;
    endfunction

    function void check_result(input out_item_t got);
      out_item_t exp;
      if (pending.size() == 0) begin
        $error("result with nothing expected");
        n_errors++;
        return;
      end
      exp = pending.pop_front();
      n_checked++;
      if (got.r_w !== exp.r_w) begin
        $error("r_w exp %h got %h", exp.r_w, got.r_w); n_errors++;
      end
      if (got.r_x !== exp.r_x) begin
        $error("r_x exp %h got %h", exp.r_x, got.r_x); n_errors++;
      end
      if (got.r_y !== exp.r_y) begin
        $error("r_y exp %h got %h", exp.r_y, got.r_y); n_errors++;
      end
      if (got.r_z !== exp.r_z) begin
        $error("r_z exp %h got %h", exp.r_z, got.r_z); n_errors++;
      end
      if (got.norm_value !== exp.norm_value) begin
        $error("norm_value exp %h got %h", exp.norm_value, got.norm_value); n_errors++;
      end
      if (got.a_is_zero !== exp.a_is_zero) begin
        $error("a_is_zero exp %b got %b", exp.a_is_zero, got.a_is_zero); n_errors++;
      end
      if (got.status !== exp.status) begin
        $error("status exp %0d got %0d", exp.status, got.status); n_errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic push = 1'b0;
  logic full;
  logic empty;
  logic pop = 1'b0;
  in_item_t in_item = '0;
  out_item_t out_item;

  qau_scoreboard sb = new();
  int unsigned send_idle_pct = 36;
  int unsigned recv_idle_pct = 67;
  int unsigned cycles = 0;

  quaternion_arithmetic_unit u_dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && push && !full) sb.note_input(in_item);
    if (rst_n && pop && !empty) sb.check_result(out_item);
    pop <= rst_n && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  function automatic logic [CW-1:0] pick_value();
    case ($urandom_range(0, 11))
      0: return '0;
      1: return SMAX;
      2: return SMIN;
      3: return '1;
      4: return 32'sd1;
      5: return 32'sd65536;
      6: return -32'sd65536;
      7: return $urandom_range(0, 1) ? 32'($urandom_range(0, 255)) : -32'($urandom_range(0, 255));
      8: return $signed($urandom()) >>> $urandom_range(8, 24);
      default: return $urandom();
    endcase
  endfunction

  function automatic in_item_t random_item();
    in_item_t it;
    it.op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                         : 3'($urandom_range(0, 4));
    it.a_w = pick_value(); it.a_x = pick_value(); it.a_y = pick_value(); it.a_z = pick_value();
    it.b_w = pick_value(); it.b_x = pick_value(); it.b_y = pick_value(); it.b_z = pick_value();
    it.divisor = pick_value();
    if ($urandom_range(0, 9) == 0) {it.a_w, it.a_x, it.a_y, it.a_z} = '0;
    return it;
  endfunction

  function automatic in_item_t make_item(input logic [2:0] op, input logic [CW-1:0] av,
                                         input logic [CW-1:0] bv, input logic [CW-1:0] dv);
    in_item_t it;
    it.op = op;
    it.a_w = av; it.a_x = av; it.a_y = -av; it.a_z = av;
    it.b_w = bv; it.b_x = -bv; it.b_y = bv; it.b_z = bv;
    it.divisor = dv;
    return it;
  endfunction

  task automatic send(input in_item_t it);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  initial begin
    in_item_t directed[$];
    int unsigned n_unknown;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    directed.push_back(make_item(OP_MUL, 32'sd65536, 32'sd131072, '0));
    directed.push_back(make_item(OP_MUL, SMAX, SMAX, '0));
    directed.push_back(make_item(OP_MUL, SMIN, SMIN, '0));
    directed.push_back(make_item(OP_MUL, SMIN, SMAX, '0));
    directed.push_back(make_item(OP_MUL, '1, 32'sd1, '0));
    directed.push_back(make_item(OP_CONJ, SMIN, '0, '0));
    directed.push_back(make_item(OP_CONJ, SMAX, '0, '0));
    directed.push_back(make_item(OP_CONJ, '0, '0, '0));
    directed.push_back(make_item(OP_DIV, 32'sd65536, '0, '0));
    directed.push_back(make_item(OP_DIV, '0, '0, '0));
    directed.push_back(make_item(OP_DIV, SMIN, '0, '1));
    directed.push_back(make_item(OP_DIV, SMAX, '0, 32'sd3));
    directed.push_back(make_item(OP_DIV, -32'sd7, '0, SMIN));
    directed.push_back(make_item(OP_NORM, SMIN, '0, '0));
    directed.push_back(make_item(OP_NORM, SMAX, '0, '0));
    directed.push_back(make_item(OP_NORM, '0, '0, '0));
    directed.push_back(make_item(OP_NORM, 32'sd65536, '0, '0));
    directed.push_back(make_item(OP_INV, '0, '0, '0));
    directed.push_back(make_item(OP_INV, 32'sd1, '0, '0));
    directed.push_back(make_item(OP_INV, 32'sd65536, '0, '0));
    directed.push_back(make_item(OP_INV, SMIN, '0, '0));
    directed.push_back(make_item(OP_SPARE, SMAX, SMAX, '0));
    directed.push_back(make_item(OP_UNUSED, '0, '1, '1));
    foreach (directed[i]) send(directed[i]);

    for (int n = 0; n < N_RANDOM; n++) begin
      if (n == N_RANDOM / 3) begin
        send_idle_pct = 67;
        recv_idle_pct = 36;
      end
      if (n == 2 * N_RANDOM / 3) begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      send(random_item());
    end
    push <= 1'b0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (400) @(posedge clk);

    n_unknown = 0;
    for (int k = OP_SPARE; k <= OP_UNUSED; k++) n_unknown += sb.n_per_op[k];
    $display("checked %0d results: mul %0d conj %0d div %0d norm %0d inv %0d",
             sb.n_checked, sb.n_per_op[OP_MUL], sb.n_per_op[OP_CONJ], sb.n_per_op[OP_DIV],
             sb.n_per_op[OP_NORM], sb.n_per_op[OP_INV]);
    $display("unknown opcodes %0d, across three sender/receiver stall mixes", n_unknown);
    if (sb.n_errors == 0 && sb.pending.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
